FILE: src/audio_clock_divider_planner_assert.svh
// Assertion macros for the audio clock divider planner checker.
// Plain text macros, no dependencies; clk_i and rst_ni must be in scope.
`ifndef AUDIO_CLOCK_DIVIDER_PLANNER_ASSERT_SVH
`define AUDIO_CLOCK_DIVIDER_PLANNER_ASSERT_SVH

// same-cycle implication
`define ACDP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ACDP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/acdp_pkg.sv
// Shared types and constants of the audio clock divider planner.
// No dependencies.
`timescale 1ns / 1ps

package acdp_pkg;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 120;

  localparam logic [63:0] VCO_LOW     = 64'd100000000;
  localparam logic [63:0] VCO_HIGH    = 64'd500000000;
  localparam logic [63:0] PLLOUT_HIGH = 64'd240000000;
  localparam logic [63:0] PPM_SCALE   = 64'd1000000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } acdp_status_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_VCO,
    S_PCHK,
    S_RFF,
    S_DV,
    S_BASE,
    S_CAND,
    S_DEN,
    S_TNUM,
    S_ERR,
    S_CMP1,
    S_CMP2,
    S_TIE1,
    S_TIE2,
    S_NEXTK,
    S_NEXTR,
    S_NEXTN,
    S_FIN,
    S_PPM1,
    S_PPM2,
    S_ACH,
    S_OUT
  } acdp_state_e;

endpackage

FILE: src/acdp_mul.sv
// Shared multiplier: AW x BW product in two half-width partial products.
// Low-half product, then high-half product, then shifted sum; no package dependencies.
`timescale 1ns / 1ps

module acdp_mul #(
  parameter int AW = 60,
  parameter int BW = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [AW-1:0]      a_i,
  input  logic [BW-1:0]      b_i,
  output logic               done_o,
  output logic [AW+BW-1:0]   p_o
);

  localparam int H  = (AW + 1) / 2;
  localparam int HW = AW - H;
  localparam int PW = AW + BW;

  logic [1:0]        cnt_q;
  logic              done_q;
  logic [H+BW-1:0]   pp_q;
  logic [H+BW-1:0]   acc_q;
  logic [HW-1:0]     ahi_q;
  logic [BW-1:0]     b_q;
  logic [PW-1:0]     p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= 2'd0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= 2'd1;
      end else if (cnt_q == 2'd1) begin
        cnt_q <= 2'd2;
      end else if (cnt_q == 2'd2) begin
        cnt_q  <= 2'd0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      pp_q  <= (H+BW)'(a_i[H-1:0]) * (H+BW)'(b_i);
      ahi_q <= a_i[AW-1:H];
      b_q   <= b_i;
    end else if (cnt_q == 2'd1) begin
      acc_q <= pp_q;
      pp_q  <= (H+BW)'(ahi_q) * (H+BW)'(b_q);
    end else if (cnt_q == 2'd2) begin
      p_q <= (PW'(pp_q) << H) + PW'(acc_q);
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

FILE: src/acdp_div.sv
// Restoring divider, one quotient bit per cycle.
// No package dependencies.
`timescale 1ns / 1ps

module acdp_div #(
  parameter int NUM_W = 33,
  parameter int DEN_W = 51
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [DEN_W-1:0]  den_i,
  output logic              done_o,
  output logic [NUM_W-1:0]  quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [NUM_W-1:0] q_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_q, q_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(NUM_W);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - CW'(1);
        done_q <= (cnt_q == CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q   <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
      q_q   <= {q_q[NUM_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = q_q;

endmodule

FILE: src/audio_clock_divider_planner.sv
// Audio clock divider planner top level: sequencer, best-candidate store.
// Uses acdp_pkg, acdp_mul and acdp_div.
//
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | reference, target, frame_scale, ppm_lim | use_external
//  m_axis   | out | mult, postdiv, half, odd, ach, num, den | status
//
// One request at a time; busy until its result is loaded into the output register.
// Multiplies and divides run on one shared unit of each kind.
// PLL mode scans all (n, r) pairs and evaluates those passing the VCO checks;
// an exact error tie adds two divides.
// A zero target or frame scale, or a zero external reference, returns as invalid.
// The output register holds while m_axis_tready is low; the next request may load.
`timescale 1ns / 1ps

module audio_clock_divider_planner #(
  parameter int MULT_MIN    = 50,
  parameter int MULT_MAX    = 500,
  parameter int POSTDIV_MIN = 2,
  parameter int POSTDIV_MAX = 7,
  parameter int SERDIV_MIN  = 4,
  parameter int SERDIV_MAX  = 511
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // reference_hz[31:0], target_hz[63:32], frame_scale[79:64], ppm_limit[99:80]
  input  logic [acdp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // use_external
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pll_mult[8:0], pll_postdiv[11:9], half_divider[19:12], odd_flag[20],
  // achieved_hz[52:21], rate_numerator[84:53], rate_denominator[112:85]
  output logic [acdp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]   m_axis_tuser
);

  localparam int NW   = $clog2(MULT_MAX + 1);
  localparam int RW   = $clog2(POSTDIV_MAX + 1);
  localparam int DW   = $clog2(SERDIV_MAX + 1);
  localparam int DENW = RW + 16 + DW;
  localparam int AW   = 32 + DENW;
  localparam int BW   = DENW;
  localparam int PW   = AW + BW;
  localparam int VCOW = 32 + NW;
  localparam int RFFW = 16 + RW;
  localparam int DVW  = 48 + RW;
  localparam int QW   = 33;

  localparam logic [31:0] POB_INIT = 32'(acdp_pkg::PLLOUT_HIGH * 64'(POSTDIV_MIN)
                                         + 64'(POSTDIV_MIN) - 64'd1);
  localparam logic [31:0] POB_STEP = 32'(acdp_pkg::PLLOUT_HIGH + 64'd1);

  acdp_pkg::acdp_state_e  state_q, state_d;
  acdp_pkg::acdp_status_e st_q;

  logic busy_q;
  logic mv_q;
  logic [acdp_pkg::M_TDATA_W-1:0] mdata_q;
  logic [1:0] muser_q;

  logic            ext_q;
  logic [31:0]     ref_q, tgt_q;
  logic [15:0]     ff_q;
  logic [19:0]     ppm_q;
  logic [NW-1:0]   n_q;
  logic [RW-1:0]   r_q;
  logic [31:0]     pob_q;
  logic [VCOW-1:0] vco_q;
  logic [RFFW-1:0] rff_q;
  logic [DVW-1:0]  dv_q;
  logic [QW-1:0]   base_q;
  logic            k_q;
  logic [DW-1:0]   d_q;
  logic [DENW-1:0] den_q;
  logic [AW-1:0]   tnum_q, err_q;
  logic [PW-1:0]   e1_q;
  logic [QW-1:0]   pl_q;
  logic [QW-1:0]   ach_q;

  logic            bv_q;
  logic [NW-1:0]   bn_q;
  logic [RW-1:0]   br_q;
  logic [DW-1:0]   bd_q;
  logic [31:0]     bnum_q;
  logic [DENW-1:0] bden_q;
  logic [AW-1:0]   berr_q, btnum_q;

  logic            mul_start, mul_done;
  logic [AW-1:0]   mul_a;
  logic [BW-1:0]   mul_b;
  logic [PW-1:0]   mul_p;
  logic            div_start, div_done;
  logic [QW-1:0]   div_num, div_q;
  logic [DVW-1:0]  div_den;

  logic [31:0]     in_ref, in_tgt;
  logic [15:0]     in_ff;
  logic [19:0]     in_ppm;
  logic            in_bad;
  logic [31:0]     cur_num;
  logic [AW-1:0]   num_x, err_c;
  logic [QW:0]     d_c;
  logic            d_ok, vco_ok, accept, out_free;

  assign in_ref = s_axis_tdata[31:0];
  assign in_tgt = s_axis_tdata[63:32];
  assign in_ff  = s_axis_tdata[79:64];
  assign in_ppm = s_axis_tdata[99:80];
  assign in_bad = (in_tgt == '0) || (in_ff == '0) || (s_axis_tuser && in_ref == '0);

  assign s_axis_tready = (state_q == acdp_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !mv_q || m_axis_tready;

  assign cur_num = ext_q ? ref_q : 32'(vco_q);
  assign num_x   = AW'(cur_num);
  assign err_c   = (num_x > tnum_q) ? num_x - tnum_q : tnum_q - num_x;
  assign d_c     = {1'b0, base_q} + (QW+1)'(k_q);
  assign d_ok    = (d_c >= (QW+1)'(SERDIV_MIN)) && (d_c <= (QW+1)'(SERDIV_MAX));
  assign vco_ok  = (64'(vco_q) >= acdp_pkg::VCO_LOW) && (64'(vco_q) <= acdp_pkg::VCO_HIGH)
                   && (64'(vco_q) <= 64'(pob_q));

  acdp_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .p_o    (mul_p)
  );

  acdp_div #(.NUM_W(QW), .DEN_W(DVW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_q)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acdp_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          if (in_bad)            state_d = acdp_pkg::S_OUT;
          else if (s_axis_tuser) state_d = acdp_pkg::S_RFF;
          else                   state_d = acdp_pkg::S_VCO;
        end
      end
      acdp_pkg::S_VCO:  if (mul_done) state_d = acdp_pkg::S_PCHK;
      acdp_pkg::S_PCHK: state_d = vco_ok ? acdp_pkg::S_RFF : acdp_pkg::S_NEXTR;
      acdp_pkg::S_RFF:  if (mul_done) state_d = acdp_pkg::S_DV;
      acdp_pkg::S_DV:   if (mul_done) state_d = acdp_pkg::S_BASE;
      acdp_pkg::S_BASE: if (div_done) state_d = acdp_pkg::S_CAND;
      acdp_pkg::S_CAND: state_d = d_ok ? acdp_pkg::S_DEN : acdp_pkg::S_NEXTK;
      acdp_pkg::S_DEN:  if (mul_done) state_d = acdp_pkg::S_TNUM;
      acdp_pkg::S_TNUM: if (mul_done) state_d = acdp_pkg::S_ERR;
      acdp_pkg::S_ERR:  state_d = bv_q ? acdp_pkg::S_CMP1 : acdp_pkg::S_NEXTK;
      acdp_pkg::S_CMP1: if (mul_done) state_d = acdp_pkg::S_CMP2;
      acdp_pkg::S_CMP2: begin
        if (mul_done) state_d = (e1_q == mul_p) ? acdp_pkg::S_TIE1 : acdp_pkg::S_NEXTK;
      end
      acdp_pkg::S_TIE1: if (div_done) state_d = acdp_pkg::S_TIE2;
      acdp_pkg::S_TIE2: if (div_done) state_d = acdp_pkg::S_NEXTK;
      acdp_pkg::S_NEXTK: begin
        if (!k_q)       state_d = acdp_pkg::S_CAND;
        else if (ext_q) state_d = acdp_pkg::S_FIN;
        else            state_d = acdp_pkg::S_NEXTR;
      end
      acdp_pkg::S_NEXTR: begin
        state_d = (r_q == RW'(POSTDIV_MAX)) ? acdp_pkg::S_NEXTN : acdp_pkg::S_PCHK;
      end
      acdp_pkg::S_NEXTN: begin
        state_d = (n_q == NW'(MULT_MAX)) ? acdp_pkg::S_FIN : acdp_pkg::S_VCO;
      end
      acdp_pkg::S_FIN: begin
        if (!bv_q)              state_d = acdp_pkg::S_OUT;
        else if (ppm_q == '0)   state_d = acdp_pkg::S_ACH;
        else                    state_d = acdp_pkg::S_PPM1;
      end
      acdp_pkg::S_PPM1: if (mul_done) state_d = acdp_pkg::S_PPM2;
      acdp_pkg::S_PPM2: begin
        if (mul_done) state_d = (e1_q > mul_p) ? acdp_pkg::S_OUT : acdp_pkg::S_ACH;
      end
      acdp_pkg::S_ACH:  if (div_done) state_d = acdp_pkg::S_OUT;
      acdp_pkg::S_OUT:  if (out_free) state_d = acdp_pkg::S_IDLE;
      default:          state_d = acdp_pkg::S_IDLE;
    endcase
  end

  // unit operands and starts
  always_comb begin
    mul_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      acdp_pkg::S_VCO: begin
        mul_start = !busy_q;
        mul_a     = AW'(ref_q);
        mul_b     = BW'(n_q);
      end
      acdp_pkg::S_RFF: begin
        mul_start = !busy_q;
        mul_a     = AW'(ff_q);
        mul_b     = BW'(r_q);
      end
      acdp_pkg::S_DV: begin
        mul_start = !busy_q;
        mul_a     = AW'(tgt_q);
        mul_b     = BW'(rff_q);
      end
      acdp_pkg::S_BASE: begin
        div_start = !busy_q;
        div_num   = QW'(cur_num);
        div_den   = dv_q;
      end
      acdp_pkg::S_DEN: begin
        mul_start = !busy_q;
        mul_a     = AW'(rff_q);
        mul_b     = BW'(d_q);
      end
      acdp_pkg::S_TNUM: begin
        mul_start = !busy_q;
        mul_a     = AW'(tgt_q);
        mul_b     = den_q;
      end
      acdp_pkg::S_CMP1: begin
        mul_start = !busy_q;
        mul_a     = err_q;
        mul_b     = bden_q;
      end
      acdp_pkg::S_CMP2: begin
        mul_start = !busy_q;
        mul_a     = berr_q;
        mul_b     = den_q;
      end
      acdp_pkg::S_TIE1: begin
        div_start = !busy_q;
        div_num   = QW'(cur_num);
        div_den   = DVW'(r_q);
      end
      acdp_pkg::S_TIE2: begin
        div_start = !busy_q;
        div_num   = QW'(bnum_q);
        div_den   = DVW'(br_q);
      end
      acdp_pkg::S_PPM1: begin
        mul_start = !busy_q;
        mul_a     = berr_q;
        mul_b     = BW'(acdp_pkg::PPM_SCALE);
      end
      acdp_pkg::S_PPM2: begin
        mul_start = !busy_q;
        mul_a     = btnum_q;
        mul_b     = BW'(ppm_q);
      end
      acdp_pkg::S_ACH: begin
        div_start = !busy_q;
        div_num   = QW'(bnum_q) + QW'(bden_q >> 1);
        div_den   = DVW'(bden_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acdp_pkg::S_IDLE;
      busy_q  <= 1'b0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (mul_start || div_start) busy_q <= 1'b1;
      else if (mul_done || div_done) busy_q <= 1'b0;
      if (state_q == acdp_pkg::S_OUT && out_free) mv_q <= 1'b1;
      else if (m_axis_tready) mv_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      acdp_pkg::S_IDLE: begin
        if (accept) begin
          ext_q <= s_axis_tuser;
          ref_q <= in_ref;
          tgt_q <= in_tgt;
          ff_q  <= in_ff;
          ppm_q <= in_ppm;
          bv_q  <= 1'b0;
          st_q  <= in_bad ? acdp_pkg::ST_INVALID : acdp_pkg::ST_OK;
          n_q   <= NW'(MULT_MIN);
          r_q   <= s_axis_tuser ? RW'(1) : RW'(POSTDIV_MIN);
          pob_q <= POB_INIT;
        end
      end
      acdp_pkg::S_VCO:  if (mul_done) vco_q <= VCOW'(mul_p);
      acdp_pkg::S_RFF:  if (mul_done) rff_q <= RFFW'(mul_p);
      acdp_pkg::S_DV:   if (mul_done) dv_q <= DVW'(mul_p);
      acdp_pkg::S_BASE: begin
        if (div_done) begin
          base_q <= div_q;
          k_q    <= 1'b0;
        end
      end
      acdp_pkg::S_CAND: d_q <= DW'(d_c);
      acdp_pkg::S_DEN:  if (mul_done) den_q <= DENW'(mul_p);
      acdp_pkg::S_TNUM: if (mul_done) tnum_q <= AW'(mul_p);
      acdp_pkg::S_ERR: begin
        err_q <= err_c;
        if (!bv_q) begin
          bv_q    <= 1'b1;
          bn_q    <= n_q;
          br_q    <= r_q;
          bd_q    <= d_q;
          bnum_q  <= cur_num;
          bden_q  <= den_q;
          berr_q  <= err_c;
          btnum_q <= tnum_q;
        end
      end
      acdp_pkg::S_CMP1: if (mul_done) e1_q <= mul_p;
      acdp_pkg::S_CMP2: begin
        if (mul_done && e1_q < mul_p) begin
          bn_q    <= n_q;
          br_q    <= r_q;
          bd_q    <= d_q;
          bnum_q  <= cur_num;
          bden_q  <= den_q;
          berr_q  <= err_q;
          btnum_q <= tnum_q;
        end
      end
      acdp_pkg::S_TIE1: if (div_done) pl_q <= div_q;
      acdp_pkg::S_TIE2: begin
        if (div_done && pl_q < div_q) begin
          bn_q    <= n_q;
          br_q    <= r_q;
          bd_q    <= d_q;
          bnum_q  <= cur_num;
          bden_q  <= den_q;
          berr_q  <= err_q;
          btnum_q <= tnum_q;
        end
      end
      acdp_pkg::S_NEXTK: k_q <= 1'b1;
      acdp_pkg::S_NEXTR: begin
        r_q   <= r_q + RW'(1);
        pob_q <= pob_q + POB_STEP;
      end
      acdp_pkg::S_NEXTN: begin
        n_q   <= n_q + NW'(1);
        r_q   <= RW'(POSTDIV_MIN);
        pob_q <= POB_INIT;
      end
      acdp_pkg::S_FIN:  if (!bv_q) st_q <= acdp_pkg::ST_INVALID;
      acdp_pkg::S_PPM1: if (mul_done) e1_q <= mul_p;
      acdp_pkg::S_PPM2: if (mul_done && e1_q > mul_p) st_q <= acdp_pkg::ST_RANGE;
      acdp_pkg::S_ACH:  if (div_done) ach_q <= div_q;
      acdp_pkg::S_OUT: begin
        if (out_free) begin
          muser_q <= st_q;
          if (st_q == acdp_pkg::ST_OK) begin
            mdata_q <= {7'd0, 28'(bden_q), bnum_q, 32'(ach_q), bd_q[0],
                        8'(bd_q >> 1),
                        ext_q ? 3'd0 : 3'(br_q),
                        ext_q ? 9'd0 : 9'(bn_q)};
          end else begin
            mdata_q <= '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;

endmodule

FILE: src/acdp_checker.sv
// Port-level checker for the audio clock divider planner, bound to the top.
// Uses acdp_pkg and audio_clock_divider_planner_assert.svh.
`timescale 1ns / 1ps
`include "audio_clock_divider_planner_assert.svh"

module acdp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [acdp_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]                     m_axis_tuser
);

  `ACDP_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")
  `ACDP_ASSERT_NOW(a_status_code, m_axis_tvalid, m_axis_tuser == acdp_pkg::ST_OK || m_axis_tuser == acdp_pkg::ST_INVALID || m_axis_tuser == acdp_pkg::ST_RANGE, "bad status code")
  `ACDP_ASSERT_NOW(a_fail_zero, m_axis_tvalid && m_axis_tuser != acdp_pkg::ST_OK, m_axis_tdata == '0, "failed plan carries data")
  `ACDP_ASSERT_NOW(a_ok_den, m_axis_tvalid && m_axis_tuser == acdp_pkg::ST_OK, m_axis_tdata[112:85] != '0, "ok plan with zero denominator")
  `ACDP_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while busy")

endmodule

bind audio_clock_divider_planner acdp_checker u_acdp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
